// ----- sv/cre_pkg.sv -----
// Shared types and constants of the character range expander.
`timescale 1ns / 1ps

package cre_pkg;

  // Code of the dash that joins the two ends of a range.
  localparam logic [7:0] DASH_CODE = 8'h2D;

  // Fill level of the two-byte window.
  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  // Depth of the command queue between front and back.
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_LOWER = 2'd1,
    CLS_UPPER = 2'd2,
    CLS_DIGIT = 2'd3
  } char_class_t;

  // One command describes every output byte that one accepted input byte causes:
  // an optional run lo..hi (a literal has lo equal to hi), then up to two
  // flushed window bytes.
  typedef struct packed {
    logic       run_vld;
    logic [7:0] run_lo;
    logic [7:0] run_hi;
    logic [1:0] flush_cnt;
    logic [7:0] flush0;
    logic [7:0] flush1;
    logic       last;
  } cmd_t;

  function automatic char_class_t char_class(input logic [7:0] c);
    char_class_t k;
    k = CLS_NONE;
    if (c >= 8'h61 && c <= 8'h7A) begin
      k = CLS_LOWER;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      k = CLS_UPPER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      k = CLS_DIGIT;
    end
    return k;
  endfunction

endpackage

// ----- sv/cre_front.sv -----
// Front end: keeps the byte window and turns each input byte into a command.
`timescale 1ns / 1ps

module cre_front
  import cre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [7:0]  win0_r, win0_nxt;
  logic [7:0]  win1_r, win1_nxt;
  logic [1:0]  fill_r, fill_nxt;
  char_class_t cls0;
  char_class_t clsc;
  logic        is_range;

  assign cls0 = char_class(win0_r);
  assign clsc = char_class(in_char);
  assign is_range = (win1_r == DASH_CODE) && (cls0 != CLS_NONE) && (cls0 == clsc) &&
                    (win0_r < in_char);

  always_comb begin
    cmd      = '0;
    win0_nxt = win0_r;
    win1_nxt = win1_r;
    fill_nxt = fill_r;
    priority if (fill_r == FILL_FULL) begin
      cmd.run_vld = 1'b1;
      cmd.run_lo  = win0_r;
      cmd.run_hi  = is_range ? in_char : win0_r;
      if (is_range) begin
        fill_nxt = FILL_EMPTY;
      end else begin
        win0_nxt = win1_r;
        win1_nxt = in_char;
      end
    end else if (fill_r == FILL_ONE) begin
      win1_nxt = in_char;
      fill_nxt = FILL_FULL;
    end else begin
      win0_nxt = in_char;
      fill_nxt = FILL_ONE;
    end
    // The fill level after the step is also the number of bytes to flush.
    cmd.flush0    = win0_nxt;
    cmd.flush1    = win1_nxt;
    cmd.flush_cnt = in_last ? fill_nxt : FILL_EMPTY;
    cmd.last      = in_last;
    if (in_last) begin
      fill_nxt = FILL_EMPTY;
      win0_nxt = '0;
      win1_nxt = '0;
    end
  end

  assign cmd_push = accept && (cmd.run_vld || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_EMPTY;
      win0_r <= '0;
      win1_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      win0_r <= win0_nxt;
      win1_r <= win1_nxt;
    end
  end

endmodule

// ----- sv/cre_queue.sv -----
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module cre_queue
  import cre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output logic full,
  output logic vld,
  output cmd_t rd_data
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  cmd_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign vld     = (cnt_r != '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- sv/cre_back.sv -----
// Back end: walks each command one output byte per cycle into the output register, unless the receiver stalls it.
`timescale 1ns / 1ps

module cre_back
  import cre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_vld,
  input  cmd_t       head,
  output logic       head_pop,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_char,
  output logic       out_last
);

  typedef enum logic [2:0] {
    PH_RUN = 3'b001,
    PH_FL0 = 3'b010,
    PH_FL1 = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       started_r, started_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic       out_vld_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic       emit;
  logic       eff_run;
  logic       eff_fl0;
  logic [7:0] byte_val;
  logic       is_final;

  assign emit = head_vld && (!out_vld_r || out_pop);

  // A command with no run starts directly at its first flushed byte.
  assign eff_run = (phase_r == PH_RUN) && head.run_vld;
  assign eff_fl0 = ((phase_r == PH_RUN) && !head.run_vld) || (phase_r == PH_FL0);

  always_comb begin
    phase_nxt   = phase_r;
    started_nxt = started_r;
    cur_nxt     = cur_r;
    if (eff_run) begin
      byte_val = started_r ? cur_r : head.run_lo;
      is_final = (byte_val == head.run_hi) && (head.flush_cnt == FILL_EMPTY);
    end else if (eff_fl0) begin
      byte_val = head.flush0;
      is_final = (head.flush_cnt == FILL_ONE);
    end else begin
      byte_val = head.flush1;
      is_final = 1'b1;
    end
    if (emit) begin
      if (is_final) begin
        phase_nxt   = PH_RUN;
        started_nxt = 1'b0;
      end else if (eff_run) begin
        if (byte_val == head.run_hi) begin
          phase_nxt   = PH_FL0;
          started_nxt = 1'b0;
        end else begin
          cur_nxt     = byte_val + 8'd1;
          started_nxt = 1'b1;
        end
      end else begin
        phase_nxt = PH_FL1;
      end
    end
  end

  assign head_pop = emit && is_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RUN;
      started_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      started_r <= started_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_char_r <= byte_val;
      out_last_r <= is_final && head.last;
    end
  end

  assign out_empty = !out_vld_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ----- sv/char_range_expander.sv -----
// Top level of the character range expander: front end, command queue, back end.
`timescale 1ns / 1ps

// The block expands ranges such as a-e, K-P or 2-7 in a byte stream into every
// code from the first end to the second. Bytes enter through a queue-style port
// (push/full) with a flag on the final byte of each string, and expanded bytes
// leave through a queue-style port (empty/pop), the final byte of each string
// flagged. A range forms only when both ends are lowercase letters, both are
// uppercase letters or both are digits and the first end is below the second;
// anything else passes through literally. After a range, scanning starts afresh,
// so a-b-c gives ab-c. The front end accepts one input transaction per cycle
// and turns it into a command for the back end; the back end produces one output
// byte per cycle unless the receiver stalls. An input byte causes 1 output byte
// as a literal, up to 26 in a full a..z range, up to 3 as a final byte that
// flushes the window. A two-entry command queue sits between the halves, so
// the front end runs ahead while a range is being expanded and stalls (full
// high) only once that queue is full. A command enters the queue at the
// accepting edge and, with nothing ahead of it and the output register free,
// reaches the output register at the next edge, where its first output byte
// can be popped.
module char_range_expander
  import cre_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       in_full,
  input  logic       out_pop,
  output logic       out_empty,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic accept;
  logic cmd_push;
  cmd_t cmd;
  logic q_full;
  logic q_vld;
  cmd_t q_head;
  logic q_pop;

  // An input transaction is taken whenever the command queue has room; the
  // front end only pushes a command when the byte actually produces output.
  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  cre_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_char  (in_char),
    .in_last  (in_last),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  cre_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .full    (q_full),
    .vld     (q_vld),
    .rd_data (q_head)
  );

  cre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (q_vld),
    .head      (q_head),
    .head_pop  (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ----- tb/char_range_expander_tb.sv -----
// Self-checking testbench of the character range expander with an in-line expansion predictor.
`timescale 1ns / 1ps

module char_range_expander_tb
  import cre_pkg::*;
;

  // Predicts every output byte that an accepted input byte causes. It also
  // holds the predicted bytes in order and compares each output transaction
  // against the oldest one.
  class expansion_checker;

    typedef struct {
      logic [7:0] ch;
      logic       last;
    } out_byte_t;

    out_byte_t   expected_bytes[$];
    logic [7:0]  window[2];
    logic [1:0]  fill;
    int unsigned failures;
    int unsigned checked;
    int unsigned ranges;

    function new();
      window[0] = 8'h00;
      window[1] = 8'h00;
      fill      = FILL_EMPTY;
      failures  = 0;
      checked   = 0;
      ranges    = 0;
    endfunction

    function char_class_t kind_of(logic [7:0] c);
      if (c >= "a" && c <= "z") return CLS_LOWER;
      if (c >= "A" && c <= "Z") return CLS_UPPER;
      if (c >= "0" && c <= "9") return CLS_DIGIT;
      return CLS_NONE;
    endfunction

    function void expect_byte(logic [7:0] c);
      out_byte_t e;
      e.ch   = c;
      e.last = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    // Called once for every accepted input transaction.
    function void note_byte(logic [7:0] c, logic is_last);
      logic [7:0]  x;
      char_class_t k;
      int unsigned v;
      x = window[0];
      k = kind_of(x);
      if (fill == FILL_FULL) begin
        if (window[1] == DASH_CODE && k != CLS_NONE && k == kind_of(c) && x < c) begin
          for (v = x; v <= c; v++) begin
            expect_byte(v[7:0]);
          end
          fill = FILL_EMPTY;
          ranges++;
        end else begin
          expect_byte(x);
          window[0] = window[1];
          window[1] = c;
        end
      end else begin
        window[fill] = c;
        fill = fill + 2'd1;
      end
      if (is_last) begin
        // Flush what is still pending; the final byte always yields a result,
        // so the newest prediction belongs to this transaction.
        if (fill != FILL_EMPTY) expect_byte(window[0]);
        if (fill == FILL_FULL) expect_byte(window[1]);
        fill = FILL_EMPTY;
        window[0] = 8'h00;
        window[1] = 8'h00;
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      end
    endfunction

    // Called once for every accepted output transaction.
    function void check_byte(logic [7:0] c, logic is_last);
      out_byte_t e;
      checked++;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: unexpected output byte %02h last %0b", $realtime, c, is_last);
        end
        return;
      end
      e = expected_bytes.pop_front();
      if (e.ch !== c || e.last !== is_last) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: output mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   $realtime, e.ch, e.last, c, is_last);
        end
      end
    endfunction

  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic [7:0] in_char;
  logic       in_last;
  logic       in_full;
  logic       out_pop;
  logic       out_empty;
  logic [7:0] out_char;
  logic       out_last;

  expansion_checker sb = new();

  // Bytes of the string that is about to be sent, and run statistics.
  logic [7:0]  text[$];
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned burst_left;
  bit          long_hold_done;

  char_range_expander dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_char   (in_char),
    .in_last   (in_last),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always #10 clk = ~clk;

  // Transactions are sampled at the rising edge, where every signal still holds
  // its value from before the edge. The input side is handled first, although
  // an output byte never leaves in the same cycle as the byte that causes it.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_push && !in_full) sb.note_byte(in_char, in_last);
      if (out_pop && !out_empty) sb.check_byte(out_char, out_last);
    end
  end

  // Offers one byte and returns at the edge where it is taken. The sender works
  // in bursts; between most bursts push drops for a random gap. A byte
  // that follows directly keeps push high without lowering it first.
  task automatic push_byte(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_push <= 1'b1;
    in_char <= c;
    in_last <= is_last;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  // Sends the bytes in text as one string, with the flag on the final byte.
  task automatic send_text();
    int i;
    for (i = 0; i < text.size(); i++) begin
      push_byte(text[i], i == text.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    int i;
    text.delete();
    for (i = 0; i < s.len(); i++) begin
      text.push_back(s[i]);
    end
  endtask

  function automatic logic [7:0] class_byte(input int k);
    unique case (k)
      CLS_LOWER: return 8'($urandom_range("a", "z"));
      CLS_UPPER: return 8'($urandom_range("A", "Z"));
      default:   return 8'($urandom_range("0", "9"));
    endcase
  endfunction

  // Builds a random string. Half of the pieces are well-formed ranges whose ends are
  // drawn from one class, so both the expanding and the literal outcome of the
  // range test occur; chained ranges, lone dashes, class bytes and fully random
  // bytes fill in the rest.
  task automatic make_random_text();
    int unsigned target;
    int unsigned pick;
    int          k;
    text.delete();
    target = $urandom_range(1, 10);
    while (text.size() < target) begin
      pick = $urandom_range(0, 9);
      k    = int'($urandom_range(CLS_LOWER, CLS_DIGIT));
      if (pick <= 4) begin
        text.push_back(class_byte(k));
        text.push_back(DASH_CODE);
        text.push_back(class_byte(k));
      end else if (pick == 5) begin
        text.push_back(DASH_CODE);
      end else if (pick == 6) begin
        text.push_back(class_byte(k));
      end else if (pick <= 8) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else begin
        text.push_back(class_byte(k));
        text.push_back(DASH_CODE);
        text.push_back(class_byte(k));
        text.push_back(DASH_CODE);
        text.push_back(class_byte(k));
      end
    end
  endtask

  // The receiver stalls on a pattern of its own: stretches of steady popping,
  // of coin-flip popping and of sparse popping. Once, early in the random part,
  // it holds off for a long stretch so that the command queue fills and the
  // block has to stall its input while the sender keeps offering bytes.
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned i;
    logic        p;
    out_pop <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(4, 40);
      for (i = 0; i < len; i++) begin
        if (!long_hold_done && sb.checked >= 60) begin
          long_hold_done = 1'b1;
          out_pop <= 1'b0;
          repeat (80) @(posedge clk);
        end
        unique case (mode)
          0:       p = 1'b1;
          1:       p = 1'($urandom_range(0, 1));
          default: p = ($urandom_range(0, 3) == 0);
        endcase
        out_pop <= p;
        @(posedge clk);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_char    <= 8'h00;
    in_last    <= 1'b0;
    bytes_sent   = 0;
    strings_sent = 0;
    burst_left   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the widest lowercase and digit ranges, a mid-size uppercase
    // range, a chain where scanning restarts after a range, a descending pair,
    // a leading dash and a dash between ends of different classes, the lowest
    // byte alone as a one-byte string, and high bytes that never form a range.
    load_text("a-z");   send_text();
    load_text("0-9");   send_text();
    load_text("K-P");   send_text();
    load_text("a-b-c"); send_text();
    load_text("z-a");   send_text();
    load_text("-a-Z");  send_text();
    text = '{8'h00};
    send_text();
    text = '{8'hFF, DASH_CODE, 8'h80};
    send_text();

    // Random part.
    while (bytes_sent < 230) begin
      make_random_text();
      send_text();
    end
    in_push <= 1'b0;

    // Wait for every predicted byte, then a little longer to catch extras.
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d bytes in %0d strings; %0d ranges expanded, %0d output bytes checked.",
             bytes_sent, strings_sent, sb.ranges, sb.checked);
    $display("Long receiver hold-off %0s, mismatches %0d.",
             long_hold_done ? "done" : "not reached", sb.failures);
    if (sb.failures == 0 && sb.expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #10_000_000;
    $display("Timeout with %0d output bytes still expected.",
             sb.expected_bytes.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cre_pkg.sv
sv/cre_front.sv
sv/cre_queue.sv
sv/cre_back.sv
sv/char_range_expander.sv
tb/char_range_expander_tb.sv
